[rtl/stde_pkg.sv]
// ----------------------------------------------------------------------------
// stde_pkg
// Shared constants and types for the spot table with dedup, eviction and
// expiry.
// ----------------------------------------------------------------------------
package stde_pkg;

  localparam int SLOTS = 128;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int KEY_W    = 64;
  localparam int BAND_W   = 5;
  localparam int TIME_W   = 32;
  localparam int MASK_W   = 16;
  localparam int AGE_W    = 17;
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 8;
  localparam int SLOT_W   = 7;

  localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(900);

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_FILTER = 2'd1;
  localparam logic [OP_W-1:0] OP_EXPIRE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [BAND_W-1:0] band;
    logic [TIME_W-1:0] stime;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] rd_addr;
    logic             eval;
    logic [IDX_W-1:0] eval_idx;
    logic             write;
    logic             load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_hold;
  } dp_stat_t;

endpackage

[rtl/stde_ctrl.sv]
// ----------------------------------------------------------------------------
// stde_ctrl
// Sequencer: takes a beat, sweeps the slots once (no sweep for opcode 3),
// writes the chosen slot on add and hands the result to the output register.
// ----------------------------------------------------------------------------
module stde_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [stde_pkg::OP_W-1:0]     in_opcode,
  output logic                          in_stall,
  input  stde_pkg::dp_stat_t            stat,
  output stde_pkg::ctl_cmd_t            cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [stde_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [stde_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [stde_pkg::CNT_W-1:0] cnt_m1;

  assign cnt_m1 = cnt_r - stde_pkg::CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    in_stall      = 1'b1;
    cmd           = '0;
    cmd.op        = op_r;
    cmd.rd_addr   = cnt_r[stde_pkg::IDX_W-1:0];
    cmd.eval_idx  = cnt_m1[stde_pkg::IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          op_nxt    = in_opcode;
          cnt_nxt   = '0;
          if (in_opcode == stde_pkg::OP_NONE) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // reads lead evaluation: a slot is evaluated in the cycle after its read
        cmd.eval = (cnt_r != '0);
        cnt_nxt  = cnt_r + stde_pkg::CNT_W'(1);
        if (cnt_r == stde_pkg::CNT_W'(stde_pkg::SLOTS)) begin
          state_nxt = (op_r == stde_pkg::OP_ADD) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_hold) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      op_r    <= stde_pkg::OP_NONE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

[rtl/stde_dp.sv]
// ----------------------------------------------------------------------------
// stde_dp
// Datapath: entry memory, valid flags, live count, scan trackers, max age
// register and the output register.
// ----------------------------------------------------------------------------
module stde_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stde_pkg::ctl_cmd_t              cmd,
  output stde_pkg::dp_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [stde_pkg::AGE_W-1:0]      cfg_wdata,
  input  logic [stde_pkg::KEY_W-1:0]      in_callsign_key,
  input  logic signed [stde_pkg::BAND_W-1:0] in_band,
  input  logic [stde_pkg::TIME_W-1:0]     in_spot_time,
  input  logic                            in_spot_active,
  input  logic [stde_pkg::MASK_W-1:0]     in_band_mask,
  input  logic [stde_pkg::TIME_W-1:0]     in_now_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stde_pkg::COUNT_W-1:0]    out_active_count,
  output logic [stde_pkg::SLOT_W-1:0]     out_slot_written,
  output logic                            out_dedup_hit
);

  stde_pkg::entry_t mem [stde_pkg::SLOTS];
  stde_pkg::entry_t rd_r;

  logic [stde_pkg::SLOTS-1:0] valid_r;
  logic [stde_pkg::CNT_W-1:0] count_r;
  logic [stde_pkg::AGE_W-1:0] max_age_r;

  // latched item
  logic [stde_pkg::KEY_W-1:0]  key_r;
  logic [stde_pkg::BAND_W-1:0] band_r;
  logic [stde_pkg::TIME_W-1:0] stime_r;
  logic                        act_r;
  logic [stde_pkg::MASK_W-1:0] mask_r;
  logic [stde_pkg::TIME_W-1:0] now_r;

  // scan trackers
  logic                         match_found_r;
  logic [stde_pkg::IDX_W-1:0]   match_idx_r;
  logic                         free_found_r;
  logic [stde_pkg::IDX_W-1:0]   free_idx_r;
  logic [stde_pkg::IDX_W-1:0]   old_idx_r;
  logic [stde_pkg::TIME_W-1:0]  old_time_r;

  logic [stde_pkg::IDX_W-1:0]   res_slot_r;
  logic                         res_hit_r;

  logic                         out_valid_r;
  logic [stde_pkg::COUNT_W-1:0] out_count_r;
  logic [stde_pkg::SLOT_W-1:0]  out_slot_r;
  logic                         out_hit_r;

  logic                         cur_valid;
  logic                         is_match;
  logic                         drop_filter;
  logic                         drop_expire;
  logic                         drop;
  logic signed [stde_pkg::TIME_W:0] age;
  logic [stde_pkg::IDX_W-1:0]   target;
  logic                         stde_unused_hi;

  assign cur_valid = valid_r[cmd.eval_idx];
  assign is_match  = cur_valid && (rd_r.key == key_r) && (rd_r.band == band_r);

  // known bands only, bit picked by the low four band bits
  assign drop_filter = cur_valid && !rd_r.band[stde_pkg::BAND_W-1]
                       && !mask_r[rd_r.band[stde_pkg::BAND_W-2:0]];

  assign age = $signed({1'b0, now_r}) - $signed({1'b0, rd_r.stime});
  assign drop_expire = cur_valid
                       && (age > $signed({{(stde_pkg::TIME_W+1-stde_pkg::AGE_W){1'b0}},
                                          max_age_r}));

  always_comb begin
    case (cmd.op)
      stde_pkg::OP_FILTER: drop = drop_filter;
      stde_pkg::OP_EXPIRE: drop = drop_expire;
      default:             drop = 1'b0;
    endcase
  end

  assign target = match_found_r ? match_idx_r :
                  free_found_r  ? free_idx_r  : old_idx_r;

  assign stde_unused_hi = 1'b0;

  // entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[target] <= '{key: key_r, band: band_r, stime: stime_r};
    end
    rd_r <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.write) begin
      valid_r[target] <= act_r;
      count_r <= count_r + stde_pkg::CNT_W'(act_r) - stde_pkg::CNT_W'(valid_r[target]);
    end else if (cmd.eval && drop) begin
      valid_r[cmd.eval_idx] <= 1'b0;
      count_r <= count_r - stde_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= stde_pkg::MAX_AGE_RESET;
    end else if (cfg_we) begin
      max_age_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r   <= in_callsign_key;
      band_r  <= in_band;
      stime_r <= in_spot_time;
      act_r   <= in_spot_active;
      mask_r  <= in_band_mask;
      now_r   <= in_now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (cmd.start) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (cmd.eval && cmd.op == stde_pkg::OP_ADD) begin
      if (is_match && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= cmd.eval_idx;
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmd.eval_idx;
      end
      // oldest, lowest index on ties
      if (cmd.eval_idx == '0 || rd_r.stime < old_time_r) begin
        old_idx_r  <= cmd.eval_idx;
        old_time_r <= rd_r.stime;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_slot_r <= '0;
      res_hit_r  <= 1'b0;
    end else if (cmd.write) begin
      res_slot_r <= target;
      res_hit_r  <= match_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= stde_unused_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count_r <= stde_pkg::COUNT_W'(count_r);
      out_slot_r  <= stde_pkg::SLOT_W'(res_slot_r);
      out_hit_r   <= res_hit_r;
    end
  end

  assign stat.out_hold      = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_active_count   = out_count_r;
  assign out_slot_written   = out_slot_r;
  assign out_dedup_hit      = out_hit_r;

endmodule

[rtl/spot_table_dedup_evict_expire.sv]
// ----------------------------------------------------------------------------
// spot_table_dedup_evict_expire
// Spot table with key/band dedup, oldest-timestamp eviction, band filter
// and age expiry, reporting the live entry count per operation.
// ----------------------------------------------------------------------------
//
//   channel | handshake                | payload
//   --------+--------------------------+--------------------------------------
//   in_     | in_valid / in_stall      | opcode, key, band, times, mask
//   out_    | out_valid / out_stall    | active_count, slot_written, dedup_hit
//   cfg_    | cfg_we                   | cfg_wdata (max age, seconds)
//
// every add, filter and expire beat sweeps all slots once through a single read
// port, one slot a cycle; opcode 3 does no sweep
// reset clears the valid flags and count at once, so no clearing pass
// a stalled result sits in the output register while the next beat runs,
// and only the hand-off of that next result waits on out_stall
//
module spot_table_dedup_evict_expire (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [stde_pkg::OP_W-1:0]           in_opcode,
  input  logic [stde_pkg::KEY_W-1:0]          in_callsign_key,
  input  logic signed [stde_pkg::BAND_W-1:0]  in_band,
  input  logic [stde_pkg::TIME_W-1:0]         in_spot_time,
  input  logic                                in_spot_active,
  input  logic [stde_pkg::MASK_W-1:0]         in_band_mask,
  input  logic [stde_pkg::TIME_W-1:0]         in_now_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stde_pkg::COUNT_W-1:0]        out_active_count,
  output logic [stde_pkg::SLOT_W-1:0]         out_slot_written,
  output logic                                out_dedup_hit,
  input  logic                                cfg_we,
  input  logic [stde_pkg::AGE_W-1:0]          cfg_wdata
);

  stde_pkg::ctl_cmd_t cmd;
  stde_pkg::dp_stat_t stat;

  stde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  stde_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_callsign_key  (in_callsign_key),
    .in_band          (in_band),
    .in_spot_time     (in_spot_time),
    .in_spot_active   (in_spot_active),
    .in_band_mask     (in_band_mask),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_active_count (out_active_count),
    .out_slot_written (out_slot_written),
    .out_dedup_hit    (out_dedup_hit)
  );

endmodule
